// ===== sv/lis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_pkg: shared types and constants for the increasing subsequence tracker
// Store sizes, opcodes, shape codes and the controller/datapath command and
// status structs.
// ----------------------------------------------------------------------------
package lis_pkg;
    localparam int MaxItems = 64;
    localparam int DimBits  = 16;
    localparam int IdxW     = $clog2(MaxItems);
    localparam int CntW     = IdxW + 1;
    localparam int KeyW     = 2 * DimBits;
    localparam int LinkW    = CntW;
    localparam logic [LinkW-1:0] NoLink = '1;

    localparam logic [1:0] OpAdd   = 2'd0;
    localparam logic [1:0] OpCount = 2'd1;
    localparam logic [1:0] OpEmit  = 2'd2;

    localparam logic [1:0] ShpSquare   = 2'd0;
    localparam logic [1:0] ShpTriangle = 2'd2;
    localparam logic [1:0] ShpBad      = 2'd3;

    // datapath commands from the controller
    typedef struct packed {
        logic capture;     // latch input word
        logic key_mul;     // compute key into key register
        logic store_item;  // write item store at item_total
        logic srch_init;   // lo=0, hi=seq_length
        logic srch_rd;     // read tail[mid]
        logic srch_key_rd; // read key of that tail
        logic srch_step;   // compare and narrow
        logic prev_rd;     // read tail[lo-1]
        logic commit;      // write tail[lo], back link, counters
        logic walk_init;   // cur = tail[len-1], pos = len
        logic walk_rd;     // read link and item of cur
        logic walk_step;   // store chain entry, advance
        logic emit_rd;     // read item at chain[k]
        logic emit_load;   // load output register
        logic emit_adv;    // k++
        logic out_simple;  // load single status result
    } lis_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       bad_shape;
        logic       srch_done;
        logic       walk_done;
        logic       seq_empty;
        logic       emit_last;
    } lis_sts_t;
endpackage

// ===== sv/lis_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lis_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/lis_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_ctrl: sequencing controller
// Steps the datapath through add, search, chain walk and emit phases.
// ----------------------------------------------------------------------------
module lis_ctrl
    import lis_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    input  logic     out_busy,
    input  logic     out_fire,
    input  lis_sts_t sts,
    output logic     in_ready,
    output lis_cmd_t cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_KEY, S_STORE, S_SRD, S_SKEY, S_SCMP, S_PREV,
        S_COMMIT, S_RESULT, S_WRD, S_WSTEP, S_ERD, S_ELOAD, S_EWAIT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.capture = in_fire;
                if (in_fire) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.op == OpAdd && !sts.full && !sts.bad_shape) begin
                    cmd.key_mul = 1'b1;
                    state_next  = S_KEY;
                end else if (sts.op == OpEmit && !sts.seq_empty) begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WRD;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_KEY: begin
                cmd.store_item = 1'b1;
                cmd.srch_init  = 1'b1;
                state_next     = S_STORE;
            end
            S_STORE: begin
                if (sts.srch_done) begin
                    cmd.prev_rd = 1'b1;
                    state_next  = S_PREV;
                end else begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_SRD: begin
                cmd.srch_key_rd = 1'b1;
                state_next      = S_SKEY;
            end
            S_SKEY: begin
                state_next = S_SCMP;
            end
            S_SCMP: begin
                cmd.srch_step = 1'b1;
                state_next    = S_STORE;
            end
            // keep the tail address on lo-1 so the link source lands at commit
            S_PREV: begin
                cmd.prev_rd = 1'b1;
                state_next  = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!out_busy) begin
                    cmd.out_simple = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_WRD: begin
                if (sts.walk_done) begin
                    state_next = S_ERD;
                end else begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WSTEP;
                end
            end
            S_WSTEP: begin
                cmd.walk_step = 1'b1;
                state_next    = S_WRD;
            end
            // chain entry is ready here, read its item
            S_ERD: begin
                cmd.emit_rd = 1'b1;
                state_next  = S_ELOAD;
            end
            S_ELOAD: begin
                cmd.emit_rd = 1'b1;
                if (!out_busy || out_fire) begin
                    cmd.emit_load = 1'b1;
                    if (sts.emit_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.emit_adv = 1'b1;
                        state_next   = S_EWAIT;
                    end
                end
            end
            S_EWAIT: begin
                state_next = S_ERD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== sv/lis_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_dp: tracker datapath
// Item store, key store, tail table, back links, chain buffer, search
// registers and the output register.
// ----------------------------------------------------------------------------
module lis_dp
    import lis_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  lis_cmd_t           cmd,
    output lis_sts_t           sts,
    input  logic [1:0]         in_op,
    input  logic [1:0]         in_shape,
    input  logic [15:0]        in_dim_a,
    input  logic [15:0]        in_dim_b,
    input  logic               out_fire,
    output logic               out_valid,
    output logic               out_status,
    output logic [6:0]         out_count,
    output logic               out_has_item,
    output logic [1:0]         out_shape,
    output logic [15:0]        out_dim_a,
    output logic [15:0]        out_dim_b,
    output logic               out_last
);
    localparam int ItemW = 2 + 2 * DimBits;

    logic [1:0]         op_reg, shape_reg;
    logic [DimBits-1:0] a_reg, b_reg;
    logic [KeyW-1:0]    key_reg;
    logic [CntW-1:0]    total_reg, len_reg;
    logic [CntW-1:0]    lo_reg, hi_reg;
    logic [IdxW-1:0]    cur_reg;
    logic [CntW-1:0]    pos_reg, k_reg;
    logic               cur_none_reg;
    logic               refused_reg;
    logic               first_reg;

    // memory ports
    logic               item_we, key_we, tail_we, link_we, chain_we;
    logic [IdxW-1:0]    item_addr, key_addr, tail_addr, link_addr, chain_addr;
    logic [ItemW-1:0]   item_wd, item_rd;
    logic [KeyW-1:0]    key_rd;
    logic [IdxW-1:0]    tail_wd, tail_rd, chain_rd;
    logic [LinkW-1:0]   link_wd, link_rd;
    logic [CntW-1:0]    mid;
    logic [CntW-1:0]    lo_m1;
    logic [CntW-1:0]    len_m1;
    logic [IdxW-1:0]    walk_cur;

    assign mid    = (lo_reg + hi_reg) >> 1;
    assign lo_m1  = lo_reg - 1'b1;
    assign len_m1 = len_reg - 1'b1;

    // first walk step takes the longest tail straight from the tail read
    assign walk_cur = first_reg ? tail_rd : cur_reg;

    // status to controller
    assign sts.op        = op_reg;
    assign sts.full      = (total_reg == CntW'(MaxItems));
    assign sts.bad_shape = (shape_reg == ShpBad);
    assign sts.srch_done = (lo_reg == hi_reg);
    assign sts.walk_done = (pos_reg == '0) || cur_none_reg;
    assign sts.seq_empty = (len_reg == '0);
    assign sts.emit_last = (k_reg == len_m1);

    // memory control
    always_comb begin
        item_we    = cmd.store_item;
        key_we     = cmd.store_item;
        item_wd    = {shape_reg, a_reg, (shape_reg == ShpSquare) ? '0 : b_reg};
        item_addr  = total_reg[IdxW-1:0];
        if (cmd.walk_rd) begin
            item_addr = walk_cur;
        end else if (cmd.emit_rd) begin
            item_addr = chain_rd;
        end
        key_addr   = cmd.store_item ? total_reg[IdxW-1:0] : tail_rd;
        tail_we    = cmd.commit;
        tail_wd    = total_reg[IdxW-1:0];
        tail_addr  = mid[IdxW-1:0];
        if (cmd.prev_rd) begin
            tail_addr = lo_m1[IdxW-1:0];
        end else if (cmd.commit) begin
            tail_addr = lo_reg[IdxW-1:0];
        end else if (cmd.walk_init) begin
            tail_addr = len_m1[IdxW-1:0];
        end
        link_we    = cmd.commit;
        link_wd    = (lo_reg == '0) ? NoLink : {1'b0, tail_rd};
        link_addr  = cmd.commit ? total_reg[IdxW-1:0] : walk_cur;
        chain_we   = cmd.walk_step;
        chain_addr = cmd.walk_step ? lo_m1[IdxW-1:0] : k_reg[IdxW-1:0];
    end

    lis_ram #(.Width(ItemW), .Depth(MaxItems)) u_item (
        .aclk(aclk), .we(item_we), .addr(item_addr), .wdata(item_wd), .rdata(item_rd));
    lis_ram #(.Width(KeyW), .Depth(MaxItems)) u_key (
        .aclk(aclk), .we(key_we), .addr(key_addr), .wdata(key_reg), .rdata(key_rd));
    lis_ram #(.Width(IdxW), .Depth(MaxItems)) u_tail (
        .aclk(aclk), .we(tail_we), .addr(tail_addr), .wdata(tail_wd), .rdata(tail_rd));
    lis_ram #(.Width(LinkW), .Depth(MaxItems)) u_link (
        .aclk(aclk), .we(link_we), .addr(link_addr), .wdata(link_wd), .rdata(link_rd));
    lis_ram #(.Width(IdxW), .Depth(MaxItems)) u_chain (
        .aclk(aclk), .we(chain_we), .addr(chain_addr), .wdata(cur_reg), .rdata(chain_rd));

    // input word and key; a full store is judged at capture time
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= in_op;
            shape_reg   <= in_shape;
            a_reg       <= in_dim_a[DimBits-1:0];
            b_reg       <= in_dim_b[DimBits-1:0];
            refused_reg <= (in_op == OpAdd) && sts.full;
        end
        if (cmd.key_mul) begin
            case (shape_reg)
                ShpSquare:   key_reg <= KeyW'(a_reg) * KeyW'(a_reg);
                ShpTriangle: key_reg <= (KeyW'(a_reg) * KeyW'(b_reg)) >> 1;
                default:     key_reg <= KeyW'(a_reg) * KeyW'(b_reg);
            endcase
        end
    end

    // search, walk and counters; lo_reg doubles as walk position scratch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            len_reg   <= '0;
        end else if (cmd.commit) begin
            total_reg <= total_reg + 1'b1;
            if (lo_reg == len_reg) begin
                len_reg <= len_reg + 1'b1;
            end
        end
        if (cmd.srch_init) begin
            lo_reg <= '0;
            hi_reg <= len_reg;
        end else if (cmd.srch_step) begin
            if (key_rd < key_reg) begin
                lo_reg <= mid + 1'b1;
            end else begin
                hi_reg <= mid;
            end
        end else if (cmd.walk_init) begin
            lo_reg <= len_reg;
        end else if (cmd.walk_step) begin
            lo_reg <= lo_m1;
        end
        if (cmd.walk_init) begin
            pos_reg      <= len_reg;
            cur_none_reg <= 1'b0;
        end else if (first_reg) begin
            cur_reg <= tail_rd;
        end else if (cmd.walk_step) begin
            pos_reg      <= pos_reg - 1'b1;
            cur_reg      <= link_rd[IdxW-1:0];
            cur_none_reg <= (link_rd == NoLink);
        end
    end

    // tail[len-1] arrives in the cycle after walk_init
    always_ff @(posedge aclk) begin
        first_reg <= cmd.walk_init;
        if (cmd.walk_init) begin
            k_reg <= '0;
        end else if (first_reg) begin
            k_reg <= pos_reg;
        end else if (cmd.walk_step) begin
            k_reg <= pos_reg - 1'b1;
        end else if (cmd.emit_adv) begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cmd.out_simple || cmd.emit_load) begin
            out_valid <= 1'b1;
        end else if (out_fire) begin
            out_valid <= 1'b0;
        end
        if (cmd.out_simple) begin
            out_status   <= refused_reg;
            out_count    <= 7'(len_reg);
            out_has_item <= 1'b0;
            out_shape    <= '0;
            out_dim_a    <= '0;
            out_dim_b    <= '0;
            out_last     <= 1'b1;
        end else if (cmd.emit_load) begin
            out_status   <= 1'b0;
            out_count    <= 7'(len_reg);
            out_has_item <= 1'b1;
            out_shape    <= item_rd[ItemW-1 -: 2];
            out_dim_a    <= 16'(item_rd[2*DimBits-1:DimBits]);
            out_dim_b    <= 16'(item_rd[DimBits-1:0]);
            out_last     <= sts.emit_last;
        end
    end
endmodule

// ===== sv/longest_increasing_subsequence_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_tracker_core: LIS tracker top level
// Slave channel takes command words (add item, count query, emit sequence);
// opcode and shape ride in s_tuser, the two dimensions in s_tdata.
// Master channel returns result words, tlast on the final word of each
// command; emit returns one word per sequence element.
// Add: decode and key multiply, then a lower-bound search over the tail table
// (up to 6 probes, each a tail read, a key read and a compare), then commit
// and result load. Count and other queries: the result word is loaded
// straight after decode. Emit: the walk follows one back link per step, then
// each output word takes a registered chain read, then a registered item read.
// One command is processed at a time; s_tready is high only when idle.
// Results sit in an output register; a stalled m_tready holds the word and
// the controller waits. Reset clears item and pile counts; stores are not
// cleared and need no sweep.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_tracker_core
    import lis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // dim_a[15:0], dim_b[31:16]
    input  logic [3:0]  s_tuser,  // opcode[1:0], shape_kind[3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // status[0], count[7:1], has_item[8],
                                  // out_shape[10:9], out_dim_a[26:11],
                                  // out_dim_b[42:27], pad[47:43]
    output logic        m_tlast
);
    logic        in_fire, out_fire;
    lis_cmd_t    cmd;
    lis_sts_t    sts;
    logic        st;
    logic [6:0]  cnt;
    logic        has;
    logic [1:0]  shp;
    logic [15:0] da, db;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    lis_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .out_busy(m_tvalid && !m_tready), .out_fire(out_fire),
        .sts(sts), .in_ready(s_tready), .cmd(cmd));

    lis_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_op(s_tuser[1:0]), .in_shape(s_tuser[3:2]),
        .in_dim_a(s_tdata[15:0]), .in_dim_b(s_tdata[31:16]),
        .out_fire(out_fire), .out_valid(m_tvalid),
        .out_status(st), .out_count(cnt), .out_has_item(has),
        .out_shape(shp), .out_dim_a(da), .out_dim_b(db), .out_last(m_tlast));

    assign m_tdata = {5'd0, db, da, shp, has, cnt, st};
endmodule
